// ===== rtl/core/srsw_pkg.sv =====
// Shared types and codes for the selective repeat sender window.
// Holds request and action codes, controller states and the command/status structs.
// Depends on nothing.
package srsw_pkg;

  // Request kinds carried on in_mode (the top code behaves as an ignored NACK)
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_NACK = 2'd2;

  localparam int MAX_WINDOW = 64;

  typedef enum logic [2:0] {
    ACT_SENT     = 3'd0,
    ACT_FULL     = 3'd1,
    ACT_ACK_OK   = 3'd2,
    ACT_ACK_IGN  = 3'd3,
    ACT_RETX     = 3'd4,
    ACT_NACK_IGN = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       can_send;
    logic       in_win;
    logic       base_eq_next;
    logic       rd_acked;
  } status_t;

  typedef struct packed {
    logic    load;
    logic    exec;
    action_t action;
    logic    wr_en;
    logic    wr_at_next;
    logic    wr_val;
    logic    inc_next;
    logic    rd_en;
    logic    inc_base;
    logic    emit;
  } cmd_t;

endpackage

// ===== rtl/core/srsw_ctrl.sv =====
// Controller for the selective repeat sender window.
// Sequences evaluate, base advance and response; uses srsw_pkg types.
module srsw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  srsw_pkg::status_t sts,
  output srsw_pkg::cmd_t   cmd,
  output logic             out_valid
);

  srsw_pkg::state_t state_r, state_nxt;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srsw_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.action = srsw_pkg::ACT_NACK_IGN;
    case (state_r)
      srsw_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = srsw_pkg::S_EVAL;
        end
      end
      srsw_pkg::S_EVAL: begin
        cmd.exec  = 1'b1;
        state_nxt = srsw_pkg::S_RESP;
        case (sts.mode)
          srsw_pkg::MODE_SEND: begin
            if (sts.can_send) begin
              cmd.action     = srsw_pkg::ACT_SENT;
              cmd.wr_en      = 1'b1;
              cmd.wr_at_next = 1'b1;
              cmd.inc_next   = 1'b1;
            end else begin
              cmd.action = srsw_pkg::ACT_FULL;
            end
          end
          srsw_pkg::MODE_ACK: begin
            if (sts.in_win) begin
              cmd.action = srsw_pkg::ACT_ACK_OK;
              cmd.wr_en  = 1'b1;
              cmd.wr_val = 1'b1;
              state_nxt  = srsw_pkg::S_READ;
            end else begin
              cmd.action = srsw_pkg::ACT_ACK_IGN;
            end
          end
          srsw_pkg::MODE_NACK: begin
            cmd.action = sts.in_win ? srsw_pkg::ACT_RETX : srsw_pkg::ACT_NACK_IGN;
          end
          default: cmd.action = srsw_pkg::ACT_NACK_IGN;
        endcase
      end
      srsw_pkg::S_READ: begin
        if (sts.base_eq_next) begin
          state_nxt = srsw_pkg::S_RESP;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = srsw_pkg::S_CHECK;
        end
      end
      srsw_pkg::S_CHECK: begin
        if (sts.rd_acked) begin
          cmd.inc_base = 1'b1;
          state_nxt    = srsw_pkg::S_READ;
        end else begin
          state_nxt = srsw_pkg::S_RESP;
        end
      end
      srsw_pkg::S_RESP: begin
        cmd.emit  = 1'b1;
        state_nxt = srsw_pkg::S_IDLE;
      end
      default: state_nxt = srsw_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state_r != srsw_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/srsw_datapath.sv =====
// Datapath for the selective repeat sender window: sequence registers,
// window register, acked-mark memory and result registers. Uses srsw_pkg.
module srsw_datapath #(
  parameter int SEQ_SPACE = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_window_size,
  input  logic [1:0]        in_mode,
  input  logic [6:0]        in_seq_number,
  input  srsw_pkg::cmd_t    cmd,
  output srsw_pkg::status_t sts,
  output logic [2:0]        out_action,
  output logic [6:0]        out_frame_seq,
  output logic [6:0]        out_window_base,
  output logic [6:0]        out_outstanding
);

  localparam int SW  = $clog2(SEQ_SPACE);
  localparam int XW  = ((SW > 7) ? SW : 7) + 1;
  localparam int LIM = (SEQ_SPACE / 2 < srsw_pkg::MAX_WINDOW) ?
                       SEQ_SPACE / 2 : srsw_pkg::MAX_WINDOW;
  localparam logic [XW-1:0] SPACE_X = XW'(SEQ_SPACE);
  localparam logic [XW-1:0] LIM_X   = XW'(LIM);
  localparam logic [SW-1:0] TOP_SEQ = SW'(SEQ_SPACE - 1);

  logic [6:0]        win_r;
  logic [SW-1:0]     base_r, next_r;
  logic [1:0]        mode_r;
  logic [6:0]        seq_r;
  srsw_pkg::action_t action_r;
  logic [XW-1:0]     fseq_r;
  logic [2:0]        out_action_r;
  logic [6:0]        out_frame_seq_r, out_window_base_r, out_outstanding_r;

  // Acked marks; a grant writes its entry before any read can reach it
  logic              mem [SEQ_SPACE];
  logic              rdata_r;

  logic [XW-1:0] base_x, next_x, seq_x, outst_x, off_x, win_x, eff_x;
  logic [SW-1:0] wr_addr;

  function automatic logic [XW-1:0] mod_sub(input logic [XW-1:0] a,
                                            input logic [XW-1:0] b);
    logic [XW-1:0] d;
    d = a - b;
    if (a < b) d = d + SPACE_X;
    return d;
  endfunction

  assign base_x  = XW'(base_r);
  assign next_x  = XW'(next_r);
  assign seq_x   = XW'(seq_r);
  assign outst_x = mod_sub(next_x, base_x);
  assign off_x   = mod_sub(seq_x, base_x);
  assign win_x   = XW'(win_r);
  assign eff_x   = (win_x > LIM_X) ? LIM_X : ((win_x == '0) ? XW'(1) : win_x);
  assign wr_addr = cmd.wr_at_next ? next_r : seq_x[SW-1:0];

  always_comb begin
    sts.mode         = mode_r;
    sts.can_send     = (outst_x < eff_x);
    sts.in_win       = (seq_x < SPACE_X) && (off_x < outst_x);
    sts.base_eq_next = (base_r == next_r);
    sts.rd_acked     = rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= 7'd4;
      base_r <= '0;
      next_r <= '0;
    end else begin
      if (cfg_wr_en) win_r <= cfg_window_size;
      if (cmd.inc_next) next_r <= (next_r == TOP_SEQ) ? '0 : next_r + 1'b1;
      if (cmd.inc_base) base_r <= (base_r == TOP_SEQ) ? '0 : base_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      seq_r  <= in_seq_number;
    end
    if (cmd.exec) begin
      action_r <= cmd.action;
      fseq_r   <= (mode_r == srsw_pkg::MODE_SEND) ? next_x : seq_x;
    end
    if (cmd.emit) begin
      out_action_r      <= action_r;
      out_frame_seq_r   <= fseq_r[6:0];
      out_window_base_r <= base_x[6:0];
      out_outstanding_r <= outst_x[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= cmd.wr_val;
    if (cmd.rd_en) rdata_r <= mem[base_r];
  end

  assign out_action      = out_action_r;
  assign out_frame_seq   = out_frame_seq_r;
  assign out_window_base = out_window_base_r;
  assign out_outstanding = out_outstanding_r;

endmodule

// ===== rtl/core/selective_repeat_sender_window.sv =====
// Top level of the selective repeat sender window.
// Instantiates srsw_ctrl and srsw_datapath; uses srsw_pkg.
//
// Usage:
//   Input channel: drive in_mode (0 send, 1 ACK, 2 NACK) and in_seq_number
//   and raise start; the request is taken at the edge where start is high
//   and busy is low. Exactly one result follows per request.
//   Result channel: out_valid is high for one cycle with out_action,
//   out_frame_seq, out_window_base and out_outstanding. The receiver cannot
//   stall; it must take the result in that cycle.
//   Configuration: cfg_wr_en writes cfg_window_size (reset 4); the user must
//   write it only while idle, which the block does not enforce. Zero acts
//   as one; values above min(64, SEQ_SPACE/2) are clamped. Sequence: a
//   request passes the evaluate and response states and its result is
//   registered. An ACK recorded in the window first walks the base, reading
//   each mark, and stops at the next sequence number or an unacked frame.
//   Throughput: a new request is taken in the cycle the result is shown.
//   Reset: rst_n low clears base, next sequence and the controller; window
//   size returns to 4. The mark memory needs no clearing pass: a grant
//   writes its mark before any read can reach it.
module selective_repeat_sender_window #(
  parameter int SEQ_SPACE = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [6:0] in_seq_number,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_window_size,
  output logic       out_valid,
  output logic [2:0] out_action,
  output logic [6:0] out_frame_seq,
  output logic [6:0] out_window_base,
  output logic [6:0] out_outstanding
);

  srsw_pkg::cmd_t    cmd;
  srsw_pkg::status_t sts;

  // Sequence the request: evaluate, walk the base, respond
  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // Hold window state and result registers
  srsw_datapath #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_window_size (cfg_window_size),
    .in_mode         (in_mode),
    .in_seq_number   (in_seq_number),
    .cmd             (cmd),
    .sts             (sts),
    .out_action      (out_action),
    .out_frame_seq   (out_frame_seq),
    .out_window_base (out_window_base),
    .out_outstanding (out_outstanding)
  );

  // An accepted request always keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Results never come in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Outstanding count never exceeds the largest legal window
  a_outst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outstanding <= 7'd64))
    else $error("outstanding count beyond largest window");

  // A granted frame is outstanding once reported
  a_sent_outst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == srsw_pkg::ACT_SENT) |-> (out_outstanding != 7'd0))
    else $error("granted frame not counted as outstanding");

endmodule
